### design/gci_pkg.sv
// shared types, constants and a helper for the grid cell center unit
`default_nettype none

package gci_pkg;

  // fixed field widths
  localparam int CNT_W   = 24;  // column / row counts and output indices
  localparam int COORD_W = 32;  // signed q16.16 coordinates
  localparam int STEP_W  = 31;  // unsigned q15.16 cell steps
  localparam int K_W     = 32;  // index width fed to the center unit
  localparam int CFG_W   = 32;  // config write data width
  localparam int CFG_A_W = 3;   // config register index width

  // centre product clamp: anything above this saturates anyway
  localparam int          PCL_W      = 41;
  localparam logic [63:0] PROD_CLAMP = 64'h0000_0100_0000_0000;

  // config register indexes
  typedef enum logic [CFG_A_W-1:0] {
    CFG_COLUMNS = 3'd0,
    CFG_ROWS    = 3'd1,
    CFG_X_LEFT  = 3'd2,
    CFG_X_STEP  = 3'd3,
    CFG_Y_TOP   = 3'd4,
    CFG_Y_STEP  = 3'd5,
    CFG_Z_TOP   = 3'd6,
    CFG_Z_STEP  = 3'd7
  } cfg_idx_t;

  // one restoring division step: returns {quotient bit, new remainder}
  function automatic logic [CNT_W:0] div_step(input logic [CNT_W-1:0] r,
                                               input logic b,
                                               input logic [CNT_W-1:0] d);
    logic [CNT_W:0] t;
    logic [CNT_W:0] diff;
    t    = {r, b};
    diff = t - {1'b0, d};
    if (t >= {1'b0, d}) begin
      div_step = {1'b1, diff[CNT_W-1:0]};
    end else begin
      div_step = {1'b0, t[CNT_W-1:0]};
    end
  endfunction

endpackage

`default_nettype wire

### design/gci_divider.sv
// pipelined restoring divider, one quotient bit per register stage
`default_nettype none

module gci_divider #(
  parameter int DW = 24,  // dividend and quotient width
  parameter int SW = 1    // sideband width carried alongside
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic [DW-1:0]             dividend,
  input  logic [gci_pkg::CNT_W-1:0] divisor,
  input  logic [SW-1:0]             side_in,
  output logic                      out_valid,
  output logic [DW-1:0]             quotient,
  output logic [gci_pkg::CNT_W-1:0] remainder,
  output logic [SW-1:0]             side_out
);

  logic                      vld  [DW];
  logic [gci_pkg::CNT_W-1:0] rem  [DW];
  logic [DW-1:0]             num  [DW];
  logic [SW-1:0]             side [DW];

  for (genvar i = 0; i < DW; i++) begin : g_stage
    logic                      vld_prev;
    logic [gci_pkg::CNT_W-1:0] rem_prev;
    logic [DW-1:0]             num_prev;
    logic [SW-1:0]             side_prev;
    logic [gci_pkg::CNT_W:0]   res;

    // stage inputs: the port for the first stage, the previous stage otherwise
    if (i == 0) begin : g_first
      assign vld_prev  = in_valid;
      assign rem_prev  = '0;
      assign num_prev  = dividend;
      assign side_prev = side_in;
    end else begin : g_next
      assign vld_prev  = vld[i-1];
      assign rem_prev  = rem[i-1];
      assign num_prev  = num[i-1];
      assign side_prev = side[i-1];
    end

    // shift in the next dividend bit, compare and subtract
    assign res = gci_pkg::div_step(rem_prev, num_prev[DW-1], divisor);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (en) begin
        vld[i] <= vld_prev;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[i]  <= res[gci_pkg::CNT_W-1:0];
        num[i]  <= {num_prev[DW-2:0], res[gci_pkg::CNT_W]};
        side[i] <= side_prev;
      end
    end
  end

  assign out_valid = vld[DW-1];
  assign quotient  = num[DW-1];
  assign remainder = rem[DW-1];
  assign side_out  = side[DW-1];

endmodule

`default_nettype wire

### design/gci_center.sv
// three-stage centre coordinate unit: split multiply, clamp, round and saturate
`default_nettype none

module gci_center (
  input  logic                        clk,
  input  logic                        en,
  input  logic                        down,   // 1: coordinate runs down from base
  input  logic [gci_pkg::K_W-1:0]     k,
  input  logic [gci_pkg::STEP_W-1:0]  step,
  input  logic [gci_pkg::COORD_W-1:0] base,
  output logic [gci_pkg::COORD_W-1:0] coord
);

  localparam int MW  = gci_pkg::K_W + 1;          // width of 2k+1
  localparam int LOW = 17;                        // low multiplier slice
  localparam int HIW = MW - LOW;                  // high multiplier slice
  localparam int VW  = gci_pkg::PCL_W + 2;        // signed q26.17 sum width

  logic [MW-1:0]                 m;
  logic [LOW+gci_pkg::STEP_W-1:0] lo_p;
  logic [HIW+gci_pkg::STEP_W-1:0] hi_p;
  logic [gci_pkg::COORD_W-1:0]   base1;
  logic [gci_pkg::COORD_W-1:0]   base2;
  logic                          down1;
  logic                          down2;
  logic [63:0]                   p;
  logic [gci_pkg::PCL_W-1:0]     p_cl;
  logic signed [VW-1:0]          base_x;
  logic signed [VW-1:0]          p_x;
  logic signed [VW-1:0]          sum;
  logic signed [VW-1:0]          half;
  logic [gci_pkg::COORD_W-1:0]   coord_next;

  assign m = {k, 1'b1};

  // stage 1: (2k+1)*step as two partial products
  always_ff @(posedge clk) begin
    if (en) begin
      lo_p  <= m[LOW-1:0] * step;
      hi_p  <= m[MW-1:LOW] * step;
      base1 <= base;
      down1 <= down;
    end
  end

  // stage 2: combine the partial products and clamp
  assign p = {hi_p, {LOW{1'b0}}} + {{(64-LOW-gci_pkg::STEP_W){1'b0}}, lo_p};

  always_ff @(posedge clk) begin
    if (en) begin
      p_cl  <= (p > gci_pkg::PROD_CLAMP) ? gci_pkg::PROD_CLAMP[gci_pkg::PCL_W-1:0]
                                         : p[gci_pkg::PCL_W-1:0];
      base2 <= base1;
      down2 <= down1;
    end
  end

  // stage 3: 2*base +/- p, round half up, saturate to 32 bits
  assign base_x = {{(VW-gci_pkg::COORD_W-1){base2[gci_pkg::COORD_W-1]}}, base2, 1'b0};
  assign p_x    = {2'b00, p_cl};
  assign sum    = down2 ? (base_x - p_x + VW'(1)) : (base_x + p_x + VW'(1));
  assign half   = sum >>> 1;

  always_comb begin
    if (half[VW-1:gci_pkg::COORD_W-1] != {(VW-gci_pkg::COORD_W+1){half[VW-1]}}) begin
      coord_next = half[VW-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      coord_next = half[gci_pkg::COORD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      coord <= coord_next;
    end
  end

endmodule

`default_nettype wire

### design/grid_cell_index_to_center_unit.sv
// top level: grid cell number to cell centre coordinates
// Usage:
//   Input stream s_*: one transaction carries a one-based cell number in
//   s_tdata. Output stream m_*: one transaction per input carries the
//   x, y, z centres (signed q16.16, saturated) and the zero-based column,
//   row and layer in m_tdata; m_tuser is set when the cell number was zero,
//   in which case all of m_tdata is zero.
//   Config port: cfg_we writes cfg_wdata into register cfg_addr; write only
//   while no transaction is in flight.
// Pipeline: input to output transaction passes the two bit-serial divider
//   pipelines (column count, then row count), three centre stages and the
//   output register.
// Throughput: one transaction per cycle while s_tready is high.
// Reset: clears the pipeline valid bits and loads the config defaults
//   (one column, one row, zero edges, unit steps).
// Stall: when m_tready is low the result waits in the output register; one
//   more result moves into a skid register, then s_tready drops and the
//   whole pipeline holds.
`default_nettype none

module grid_cell_index_to_center_unit #(
  parameter int INDEX_BITS = 24
) (
  input  logic                              clk,
  input  logic                              rst,
  // cell_number
  input  logic [((INDEX_BITS+7)/8)*8-1:0]   s_tdata,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // x_center, y_center, z_center, column_index, row_index, layer_index
  output logic [167:0]                      m_tdata,
  // invalid_cell
  output logic                              m_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  input  logic                              cfg_we,
  input  logic [gci_pkg::CFG_A_W-1:0]       cfg_addr,
  input  logic [gci_pkg::CFG_W-1:0]         cfg_wdata
);

  localparam int CW = gci_pkg::CNT_W;
  localparam int DW = INDEX_BITS;
  localparam int CL = 3;  // centre unit latency

  // config registers
  logic [CW-1:0]                  columns;
  logic [CW-1:0]                  rows;
  logic [gci_pkg::COORD_W-1:0]    x_left;
  logic [gci_pkg::STEP_W-1:0]     x_step;
  logic [gci_pkg::COORD_W-1:0]    y_top;
  logic [gci_pkg::STEP_W-1:0]     y_step;
  logic [gci_pkg::COORD_W-1:0]    z_top;
  logic [gci_pkg::STEP_W-1:0]     z_step;

  logic                           adv;
  logic [DW-1:0]                  n;
  logic                           d1_valid;
  logic [DW-1:0]                  d1_q;
  logic [CW-1:0]                  d1_r;
  logic                           d1_inv;
  logic                           d2_valid;
  logic [DW-1:0]                  d2_q;
  logic [CW-1:0]                  d2_r;
  logic [CW:0]                    d2_side;
  logic [gci_pkg::K_W-1:0]        layer_k;
  logic [gci_pkg::COORD_W-1:0]    x_c;
  logic [gci_pkg::COORD_W-1:0]    y_c;
  logic [gci_pkg::COORD_W-1:0]    z_c;

  logic                           dl_valid [CL];
  logic [CW-1:0]                  dl_col   [CL];
  logic [CW-1:0]                  dl_row   [CL];
  logic [CW-1:0]                  dl_layer [CL];
  logic                           dl_inv   [CL];

  logic [167:0]                   pl_data;
  logic                           pl_valid;
  logic                           skid_valid;
  logic [167:0]                   skid_data;
  logic                           skid_user;
  logic                           out_free;

  // config writes, a zero count reads as one
  always_ff @(posedge clk) begin
    if (rst) begin
      columns <= CW'(1);
      rows    <= CW'(1);
      x_left  <= '0;
      x_step  <= gci_pkg::STEP_W'(65536);
      y_top   <= '0;
      y_step  <= gci_pkg::STEP_W'(65536);
      z_top   <= '0;
      z_step  <= gci_pkg::STEP_W'(65536);
    end else if (cfg_we) begin
      case (gci_pkg::cfg_idx_t'(cfg_addr))
        gci_pkg::CFG_COLUMNS: columns <= (cfg_wdata[CW-1:0] == '0) ? CW'(1) : cfg_wdata[CW-1:0];
        gci_pkg::CFG_ROWS:    rows    <= (cfg_wdata[CW-1:0] == '0) ? CW'(1) : cfg_wdata[CW-1:0];
        gci_pkg::CFG_X_LEFT:  x_left  <= cfg_wdata;
        gci_pkg::CFG_X_STEP:  x_step  <= cfg_wdata[gci_pkg::STEP_W-1:0];
        gci_pkg::CFG_Y_TOP:   y_top   <= cfg_wdata;
        gci_pkg::CFG_Y_STEP:  y_step  <= cfg_wdata[gci_pkg::STEP_W-1:0];
        gci_pkg::CFG_Z_TOP:   z_top   <= cfg_wdata;
        gci_pkg::CFG_Z_STEP:  z_step  <= cfg_wdata[gci_pkg::STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // whole pipeline moves while the skid register is empty
  assign adv      = !skid_valid;
  assign s_tready = adv;
  assign n        = s_tdata[DW-1:0];

  // zero-based number split by the column count
  gci_divider #(.DW(DW), .SW(1)) u_div_col (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (s_tvalid),
    .dividend  (n - DW'(1)),
    .divisor   (columns),
    .side_in   (n == '0),
    .out_valid (d1_valid),
    .quotient  (d1_q),
    .remainder (d1_r),
    .side_out  (d1_inv)
  );

  // quotient split by the row count
  gci_divider #(.DW(DW), .SW(CW + 1)) u_div_row (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (d1_valid),
    .dividend  (d1_q),
    .divisor   (rows),
    .side_in   ({d1_r, d1_inv}),
    .out_valid (d2_valid),
    .quotient  (d2_q),
    .remainder (d2_r),
    .side_out  (d2_side)
  );

  assign layer_k = gci_pkg::K_W'(d2_q);

  // centre coordinates
  gci_center u_center_x (
    .clk   (clk),
    .en    (adv),
    .down  (1'b0),
    .k     (gci_pkg::K_W'(d2_side[CW:1])),
    .step  (x_step),
    .base  (x_left),
    .coord (x_c)
  );

  gci_center u_center_y (
    .clk   (clk),
    .en    (adv),
    .down  (1'b1),
    .k     (gci_pkg::K_W'(d2_r)),
    .step  (y_step),
    .base  (y_top),
    .coord (y_c)
  );

  gci_center u_center_z (
    .clk   (clk),
    .en    (adv),
    .down  (1'b1),
    .k     (layer_k),
    .step  (z_step),
    .base  (z_top),
    .coord (z_c)
  );

  // indices and flag ride alongside the centre stages
  for (genvar i = 0; i < CL; i++) begin : g_dl
    always_ff @(posedge clk) begin
      if (rst) begin
        dl_valid[i] <= 1'b0;
      end else if (adv) begin
        dl_valid[i] <= (i == 0) ? d2_valid : dl_valid[(i == 0) ? 0 : i-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        if (i == 0) begin
          dl_col[i]   <= d2_side[CW:1];
          dl_row[i]   <= d2_r;
          dl_layer[i] <= layer_k[CW-1:0];
          dl_inv[i]   <= d2_side[0];
        end else begin
          dl_col[i]   <= dl_col[(i == 0) ? 0 : i-1];
          dl_row[i]   <= dl_row[(i == 0) ? 0 : i-1];
          dl_layer[i] <= dl_layer[(i == 0) ? 0 : i-1];
          dl_inv[i]   <= dl_inv[(i == 0) ? 0 : i-1];
        end
      end
    end
  end

  // result word, all zero for an invalid cell number
  assign pl_valid = dl_valid[CL-1];
  assign pl_data  = dl_inv[CL-1] ? '0
                  : {dl_layer[CL-1], dl_row[CL-1], dl_col[CL-1], z_c, y_c, x_c};

  // output register with skid stage
  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      m_tvalid   <= skid_valid || (adv && pl_valid);
      skid_valid <= 1'b0;
    end else if (adv && pl_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        m_tdata <= skid_data;
        m_tuser <= skid_user;
      end else begin
        m_tdata <= pl_data;
        m_tuser <= dl_inv[CL-1];
      end
    end else if (adv && pl_valid) begin
      skid_data <= pl_data;
      skid_user <= dl_inv[CL-1];
    end
  end

endmodule

`default_nettype wire

### bench/tb.sv
// testbench for the grid cell number to cell center unit
`timescale 1ns / 1ps

module tb;

  localparam int IDX_W    = 24;
  localparam int PIPE_LAT = 2 * IDX_W + 4;
  localparam int WATCHDOG = 4000;
  localparam longint Q_MAX = 64'sd2147483647;
  localparam longint Q_MIN = -64'sd2147483648;
  localparam longint unsigned SPAN_CLAMP = 64'd1 << 40;

  // one result transaction, laid out as {m_tuser, m_tdata}
  typedef struct packed {
    logic        bad;
    logic [23:0] layer;
    logic [23:0] row;
    logic [23:0] col;
    logic [31:0] z;
    logic [31:0] y;
    logic [31:0] x;
  } cell_center_t;

  // directed stimulus row: a register write or a cell number
  typedef struct {
    bit                 is_reg;
    gci_pkg::cfg_idx_t  reg_idx;
    logic [31:0]        reg_val;
    logic [23:0]        cell_no;
    bit                 typed;
    cell_center_t       want;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic [23:0] s_tdata = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [167:0] m_tdata;
  logic m_tuser;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic cfg_we = 1'b0;
  logic [gci_pkg::CFG_A_W-1:0] cfg_addr = '0;
  logic [gci_pkg::CFG_W-1:0] cfg_wdata = '0;

  // hand-typed expectation travelling with the current cell number
  bit lit_valid = 1'b0;
  cell_center_t lit_want = '0;

  // local copy of the register file
  logic [23:0] grid_cols = 24'd1;
  logic [23:0] grid_rows = 24'd1;
  logic signed [31:0] x_origin = '0;
  logic [30:0] x_pitch = 31'd65536;
  logic signed [31:0] y_origin = '0;
  logic [30:0] y_pitch = 31'd65536;
  logic signed [31:0] z_origin = '0;
  logic [30:0] z_pitch = 31'd65536;

  cell_center_t pending_centers[$];
  plan_row_t plan[$];
  int fail_count = 0;
  int idle_cycles = 0;
  bit calm = 1'b0;

  grid_cell_index_to_center_unit #(.INDEX_BITS(IDX_W)) dut (
    .clk(clk),
    .rst(rst),
    .s_tdata(s_tdata),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .cfg_we(cfg_we),
    .cfg_addr(cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // origin +/- (k + 1/2) * pitch, rounded half up, saturated to q16.16
  function automatic logic [31:0] center_coord(logic signed [31:0] origin,
                                               longint unsigned k,
                                               logic [30:0] pitch, bit down);
    longint unsigned span;
    longint v;
    longint r;
    span = (2 * k + 1) * 64'(pitch);
    if (span > SPAN_CLAMP) span = SPAN_CLAMP;
    v = down ? 2 * longint'(origin) - longint'(span)
             : 2 * longint'(origin) + longint'(span);
    r = (v + 1) >>> 1;
    if (r > Q_MAX) r = Q_MAX;
    if (r < Q_MIN) r = Q_MIN;
    return r[31:0];
  endfunction

  // split a one-based cell number and place the cell center
  function automatic cell_center_t locate_cell(logic [23:0] n);
    cell_center_t res;
    longint unsigned nc, nr, c, q, col, row, layer;
    res = '0;
    if (n == 0) begin
      res.bad = 1'b1;
      return res;
    end
    nc = (grid_cols == 0) ? 1 : 64'(grid_cols);
    nr = (grid_rows == 0) ? 1 : 64'(grid_rows);
    c = 64'(n) - 1;
    col = c % nc;
    q = c / nc;
    row = q % nr;
    layer = q / nr;
    res.x = center_coord(x_origin, col, x_pitch, 1'b0);
    res.y = center_coord(y_origin, row, y_pitch, 1'b1);
    res.z = center_coord(z_origin, layer, z_pitch, 1'b1);
    res.col = col[23:0];
    res.row = row[23:0];
    res.layer = layer[23:0];
    return res;
  endfunction

  function automatic cell_center_t make_center(logic [31:0] x, logic [31:0] y,
                                               logic [31:0] z, logic [23:0] col,
                                               logic [23:0] row, logic [23:0] layer,
                                               logic bad);
    cell_center_t res;
    res.x = x;
    res.y = y;
    res.z = z;
    res.col = col;
    res.row = row;
    res.layer = layer;
    res.bad = bad;
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (fail_count < 40) $display("mismatch %s: got %h, expected %h", what, got, want);
    fail_count++;
  endtask

  task automatic compare_center(cell_center_t got, cell_center_t want);
    if (got.x !== want.x) report_mismatch("x_center", got.x, want.x);
    if (got.y !== want.y) report_mismatch("y_center", got.y, want.y);
    if (got.z !== want.z) report_mismatch("z_center", got.z, want.z);
    if (got.col !== want.col)
      report_mismatch("column_index", 32'(got.col), 32'(want.col));
    if (got.row !== want.row)
      report_mismatch("row_index", 32'(got.row), 32'(want.row));
    if (got.layer !== want.layer)
      report_mismatch("layer_index", 32'(got.layer), 32'(want.layer));
    if (got.bad !== want.bad)
      report_mismatch("invalid_cell", 32'(got.bad), 32'(want.bad));
  endtask

  task automatic add_reg(gci_pkg::cfg_idx_t idx, logic [31:0] val);
    plan_row_t r;
    r = '{is_reg: 1'b1, reg_idx: idx, reg_val: val, cell_no: '0, typed: 1'b0, want: '0};
    plan.push_back(r);
  endtask

  task automatic add_cell(logic [23:0] n, bit typed, cell_center_t want);
    plan_row_t r;
    r = '{is_reg: 1'b0, reg_idx: gci_pkg::CFG_COLUMNS, reg_val: '0, cell_no: n,
          typed: typed, want: want};
    plan.push_back(r);
  endtask

  // stop sending and wait for every pending center to come back
  task automatic drain();
    s_tvalid <= 1'b0;
    cfg_we <= 1'b0;
    @(posedge clk);
    while (pending_centers.size() != 0) @(posedge clk);
  endtask

  // register write, only with the pipeline empty
  task automatic write_reg(gci_pkg::cfg_idx_t idx, logic [31:0] val);
    drain();
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      gci_pkg::CFG_COLUMNS: grid_cols = val[23:0];
      gci_pkg::CFG_ROWS:    grid_rows = val[23:0];
      gci_pkg::CFG_X_LEFT:  x_origin = val;
      gci_pkg::CFG_X_STEP:  x_pitch = val[30:0];
      gci_pkg::CFG_Y_TOP:   y_origin = val;
      gci_pkg::CFG_Y_STEP:  y_pitch = val[30:0];
      gci_pkg::CFG_Z_TOP:   z_origin = val;
      gci_pkg::CFG_Z_STEP:  z_pitch = val[30:0];
      default: ;
    endcase
  endtask

  // one input transaction, with random idle cycles in front
  task automatic send_cell(logic [23:0] n, bit typed, cell_center_t want);
    cfg_we <= 1'b0;
    while (!calm && $urandom_range(99) < 28) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tdata <= n;
    s_tvalid <= 1'b1;
    lit_valid <= typed;
    lit_want <= want;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_count();
    logic [23:0] cnt;
    case ($urandom_range(5))
      0: cnt = '0;
      1: cnt = 24'd1;
      2: cnt = 24'($urandom_range(2, 16));
      3: cnt = 24'($urandom_range(17, 4096));
      4: cnt = 24'hFFFFFF;
      default: cnt = 24'($urandom);
    endcase
    return {($urandom_range(1) != 0) ? 8'($urandom) : 8'h00, cnt};
  endfunction

  function automatic logic [31:0] pick_origin();
    case ($urandom_range(4))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return {{8{1'b0}}, 24'($urandom)} - 32'h0080_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_pitch();
    logic [30:0] p;
    case ($urandom_range(4))
      0: p = '0;
      1: p = 31'h7FFF_FFFF;
      2: p = 31'($urandom_range(1, 32'h0004_0000));
      default: p = 31'($urandom);
    endcase
    return {1'($urandom), p};
  endfunction

  function automatic logic [31:0] pick_reg(gci_pkg::cfg_idx_t idx);
    case (idx)
      gci_pkg::CFG_COLUMNS, gci_pkg::CFG_ROWS: return pick_count();
      gci_pkg::CFG_X_LEFT, gci_pkg::CFG_Y_TOP, gci_pkg::CFG_Z_TOP: return pick_origin();
      default: return pick_pitch();
    endcase
  endfunction

  // 40 percent cells inside the first four layers of the grid, 5 percent zero, 5 percent all ones, the rest anywhere
  function automatic logic [23:0] pick_cell();
    longint unsigned span;
    int roll;
    span = 64'((grid_cols == 0) ? 24'd1 : grid_cols) *
           64'((grid_rows == 0) ? 24'd1 : grid_rows) * 4;
    if (span > 64'hFFFFFF) span = 64'hFFFFFF;
    roll = $urandom_range(99);
    if (roll < 5) return '0;
    if (roll < 10) return 24'hFFFFFF;
    if (roll < 50) return 24'($urandom_range(1, 32'(span)));
    return 24'($urandom);
  endfunction

  // receiver stalls
  always @(posedge clk) begin
    m_tready <= calm || ($urandom_range(99) >= 28);
  end

  // check results first, then record the expectation of a new cell number
  always @(posedge clk) begin
    cell_center_t got;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got = {m_tuser, m_tdata};
        if (pending_centers.size() == 0)
          report_mismatch("result with nothing pending", got.x, '0);
        else
          compare_center(got, pending_centers.pop_front());
      end
      if (s_tvalid && s_tready)
        pending_centers.push_back(lit_valid ? lit_want : locate_cell(s_tdata));
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    // reset defaults: one column, one row, zero edges, unit steps
    add_cell(24'd0, 1'b1, make_center('0, '0, '0, '0, '0, '0, 1'b1));
    add_cell(24'd1, 1'b1, make_center(32'h0000_8000, 32'hFFFF_8000, 32'hFFFF_8000,
                                      '0, '0, '0, 1'b0));
    add_cell(24'd2, 1'b1, make_center(32'h0000_8000, 32'hFFFF_8000, 32'hFFFE_8000,
                                      '0, '0, 24'd1, 1'b0));
    // huge layer saturates z
    add_cell(24'hFFFFFF, 1'b1, make_center(32'h0000_8000, 32'hFFFF_8000, 32'h8000_0000,
                                           '0, '0, 24'hFFFFFE, 1'b0));
    // small 4 x 3 grid
    add_reg(gci_pkg::CFG_COLUMNS, 32'd4);
    add_reg(gci_pkg::CFG_ROWS, 32'd3);
    add_reg(gci_pkg::CFG_X_LEFT, 32'hFFFF_0000);
    add_reg(gci_pkg::CFG_X_STEP, 32'h0002_0000);
    add_reg(gci_pkg::CFG_Y_TOP, 32'h000A_0000);
    add_reg(gci_pkg::CFG_Y_STEP, 32'h0001_0000);
    add_reg(gci_pkg::CFG_Z_TOP, 32'h0000_0000);
    add_reg(gci_pkg::CFG_Z_STEP, 32'h0000_8000);
    add_cell(24'd1, 1'b0, '0);
    add_cell(24'd4, 1'b0, '0);
    add_cell(24'd5, 1'b0, '0);
    add_cell(24'd12, 1'b0, '0);
    add_cell(24'd13, 1'b0, '0);
    add_cell(24'hFFFFFF, 1'b0, '0);
    add_cell(24'd0, 1'b1, make_center('0, '0, '0, '0, '0, '0, 1'b1));
    // zero counts act as one, coordinates pinned at both limits
    add_reg(gci_pkg::CFG_COLUMNS, 32'd0);
    add_reg(gci_pkg::CFG_ROWS, 32'd0);
    add_reg(gci_pkg::CFG_X_LEFT, 32'h7FFF_FFFF);
    add_reg(gci_pkg::CFG_X_STEP, 32'h7FFF_FFFF);
    add_reg(gci_pkg::CFG_Y_TOP, 32'h8000_0000);
    add_reg(gci_pkg::CFG_Y_STEP, 32'h7FFF_FFFF);
    add_reg(gci_pkg::CFG_Z_TOP, 32'h8000_0000);
    add_reg(gci_pkg::CFG_Z_STEP, 32'h0000_0000);
    add_cell(24'd1, 1'b1, make_center(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                                      '0, '0, '0, 1'b0));
    add_cell(24'hFFFFFF, 1'b0, '0);
    add_cell(24'd0, 1'b1, make_center('0, '0, '0, '0, '0, '0, 1'b1));
    // full-size counts, zero steps, rounding of an exact half
    add_reg(gci_pkg::CFG_COLUMNS, 32'h00FF_FFFF);
    add_reg(gci_pkg::CFG_ROWS, 32'h00FF_FFFF);
    add_reg(gci_pkg::CFG_X_LEFT, 32'h8000_0000);
    add_reg(gci_pkg::CFG_X_STEP, 32'h0000_0000);
    add_reg(gci_pkg::CFG_Y_TOP, 32'h7FFF_FFFF);
    add_reg(gci_pkg::CFG_Y_STEP, 32'h0000_0000);
    add_reg(gci_pkg::CFG_Z_TOP, 32'h0000_0000);
    add_reg(gci_pkg::CFG_Z_STEP, 32'h0000_0001);
    add_cell(24'd1, 1'b1, make_center(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000,
                                      '0, '0, '0, 1'b0));
    add_cell(24'hFFFFFF, 1'b0, '0);

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].is_reg) write_reg(plan[i].reg_idx, plan[i].reg_val);
      else send_cell(plan[i].cell_no, plan[i].typed, plan[i].want);
    end

    // random phases, each with a fresh register setting
    for (int ph = 0; ph < 8; ph++) begin
      calm = (ph == 3);
      for (int r = 0; r < 8; r++)
        write_reg(gci_pkg::cfg_idx_t'(r), pick_reg(gci_pkg::cfg_idx_t'(r)));
      for (int i = 0; i < 67; i++) begin
        if (i == 33) drain();
        send_cell(pick_cell(), 1'b0, '0);
      end
    end
    calm = 1'b0;

    s_tvalid <= 1'b0;
    while (pending_centers.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 8) @(posedge clk);
    if (fail_count == 0 && pending_centers.size() == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
